### hw/rtl/expert_slot_lru_cache_unit_assert.svh
// ---------------------------------------------------------------------------
// Expert slot cache assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef EXPERT_SLOT_LRU_CACHE_UNIT_ASSERT_SVH
`define EXPERT_SLOT_LRU_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define ESLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("expert slot cache: assertion failed");

// next-cycle implication
`define ESLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("expert slot cache: assertion failed");

`endif

### hw/rtl/eslc_pkg.sv
// ---------------------------------------------------------------------------
// Expert slot cache package
// Widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package eslc_pkg;

  localparam int unsigned WAYS_DEFAULT = 8;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned OFF_W   = 40;
  localparam int unsigned EB_W    = 32;
  localparam int unsigned SL_W    = 40;
  localparam int unsigned CFG_W   = 40;
  localparam int unsigned LOC_W   = 35;
  localparam int unsigned ENT_W   = 3;
  localparam int unsigned STAMP_W = 64;

  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 40;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_LOADED  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic REG_BLOCK_BYTES   = 1'b0;
  localparam logic REG_SOURCE_LENGTH = 1'b1;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/eslc_ctrl.sv
// ---------------------------------------------------------------------------
// Expert slot cache controller
// Sequences each request through lookup and update, gated by the output.
// ---------------------------------------------------------------------------
module eslc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  eslc_pkg::stat_t stat,
  output eslc_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t state;
  logic   commit;

  assign commit   = (state == S_UPD) && stat.out_free;
  assign in_ready = (state == S_IDLE) || commit;

  assign cmd.load   = in_valid && in_ready;
  assign cmd.eval   = (state == S_LOOK);
  assign cmd.commit = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (commit) begin
            state <= in_valid ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/eslc_datapath.sv
// ---------------------------------------------------------------------------
// Expert slot cache datapath
// Tag match, stamp minimum tree, bounds check, entry store and result register.
// ---------------------------------------------------------------------------
module eslc_datapath #(
  parameter int unsigned WAYS = eslc_pkg::WAYS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  eslc_pkg::cmd_t                cmd,
  output eslc_pkg::stat_t               stat,
  input  logic                          in_op,
  input  logic [eslc_pkg::ID_W-1:0]     in_id,
  input  logic [eslc_pkg::OFF_W-1:0]    in_off,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [eslc_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output eslc_pkg::status_t             out_status,
  output logic [eslc_pkg::ENT_W-1:0]    out_entry,
  output logic [eslc_pkg::LOC_W-1:0]    out_loc
);

  localparam int unsigned IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned P  = 2 ** IW;
  localparam int unsigned PW = eslc_pkg::EB_W + IW;

  typedef logic [IW-1:0] mod_tab_t [256];

  function automatic mod_tab_t mod_table(input int unsigned scale);
    mod_tab_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = IW'((i * scale) % WAYS);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_LO = mod_table(1);
  localparam mod_tab_t MOD_HI = mod_table(256);

  // configuration
  logic [eslc_pkg::EB_W-1:0] block_bytes;
  logic [eslc_pkg::SL_W-1:0] source_length;

  // cache state
  logic [WAYS-1:0]              entry_valid;
  logic [eslc_pkg::ID_W-1:0]    entry_tag [WAYS];
  logic [eslc_pkg::STAMP_W-1:0] entry_stamp [WAYS];
  logic [eslc_pkg::LOC_W-1:0]   loc_mem [WAYS];
  logic [eslc_pkg::STAMP_W-1:0] use_counter;

  // request registers
  logic                       op_q;
  logic [eslc_pkg::ID_W-1:0]  id_q;
  logic [eslc_pkg::OFF_W-1:0] off_q;
  logic [IW-1:0]              res_q;

  // lookup results
  logic                       hit_q;
  logic [IW-1:0]              hit_idx_q;
  logic [eslc_pkg::LOC_W-1:0] loc_rd_q;
  logic                       range_fail_q;
  logic [IW-1:0]              victim_q;
  logic [eslc_pkg::LOC_W-1:0] prod_q;

  logic [IW:0]                  res_sum;
  logic [IW-1:0]                res_next;
  logic [WAYS-1:0]              match;
  logic                         hit;
  logic [IW-1:0]                hit_idx;
  logic [eslc_pkg::STAMP_W-1:0] node_val [2*P];
  logic [IW-1:0]                node_idx [2*P];
  logic [IW-1:0]                victim;
  logic [eslc_pkg::OFF_W:0]     end_sum;
  logic [PW-1:0]                prod;
  logic [eslc_pkg::STAMP_W-1:0] counter_inc;

  assign stat.out_free = !out_valid || out_ready;

  // id mod WAYS from two byte tables
  always_comb begin
    res_sum = {1'b0, MOD_LO[in_id[7:0]]} + {1'b0, MOD_HI[in_id[15:8]]};
    if (res_sum >= (IW + 1)'(WAYS)) begin
      res_next = IW'(res_sum - (IW + 1)'(WAYS));
    end else begin
      res_next = res_sum[IW-1:0];
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = entry_valid[i] && (entry_tag[i] == id_q);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // minimum stamp tree, lower index wins ties
  always_comb begin
    for (int n = 0; n < 2 * P; n++) begin
      node_val[n] = '1;
      node_idx[n] = '0;
    end
    for (int n = 0; n < P; n++) begin
      if (n < WAYS) begin
        node_val[P+n] = entry_stamp[n];
      end
      node_idx[P+n] = IW'(n);
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (node_val[2*n+1] < node_val[2*n]) begin
        node_val[n] = node_val[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_val[n] = node_val[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
    victim = (node_val[1] < use_counter) ? node_idx[1] : '0;
  end

  assign end_sum     = {1'b0, off_q} + (eslc_pkg::OFF_W + 1)'(block_bytes);
  assign prod        = PW'(res_q) * PW'(block_bytes);
  assign counter_inc = use_counter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= eslc_pkg::EB_W'(1);
      source_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eslc_pkg::REG_BLOCK_BYTES:   block_bytes   <= cfg_data[eslc_pkg::EB_W-1:0];
        eslc_pkg::REG_SOURCE_LENGTH: source_length <= cfg_data[eslc_pkg::SL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      id_q  <= in_id;
      off_q <= in_off;
      res_q <= res_next;
    end
    if (cmd.eval) begin
      hit_q        <= hit;
      hit_idx_q    <= hit_idx;
      loc_rd_q     <= loc_mem[hit_idx];
      range_fail_q <= end_sum > {1'b0, source_length};
      victim_q     <= victim;
      prod_q       <= prod[eslc_pkg::LOC_W-1:0];
    end
    if (cmd.commit && op_q == eslc_pkg::OP_LOOKUP && !hit_q && !range_fail_q) begin
      entry_tag[victim_q] <= id_q;
      loc_mem[victim_q]   <= prod_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      use_counter <= '0;
      for (int i = 0; i < WAYS; i++) begin
        entry_stamp[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (op_q == eslc_pkg::OP_CLEAR) begin
        entry_valid <= '0;
        use_counter <= '0;
        for (int i = 0; i < WAYS; i++) begin
          entry_stamp[i] <= '0;
        end
      end else if (hit_q) begin
        use_counter            <= counter_inc;
        entry_stamp[hit_idx_q] <= counter_inc;
      end else if (!range_fail_q) begin
        use_counter           <= counter_inc;
        entry_stamp[victim_q] <= counter_inc;
        entry_valid[victim_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_q == eslc_pkg::OP_CLEAR) begin
        out_status <= eslc_pkg::ST_CLEARED;
        out_entry  <= '0;
        out_loc    <= '0;
      end else if (hit_q) begin
        out_status <= eslc_pkg::ST_HIT;
        out_entry  <= eslc_pkg::ENT_W'(hit_idx_q);
        out_loc    <= loc_rd_q;
      end else if (range_fail_q) begin
        out_status <= eslc_pkg::ST_RANGE;
        out_entry  <= '0;
        out_loc    <= '0;
      end else begin
        out_status <= eslc_pkg::ST_LOADED;
        out_entry  <= eslc_pkg::ENT_W'(victim_q);
        out_loc    <= prod_q;
      end
    end
  end

endmodule

### hw/rtl/expert_slot_lru_cache_unit.sv
// An accepted request is registered, evaluated in the lookup state and its result
// registered in the update state. Each request passes through the lookup state (tag match and
// stamp minimum tree) and then the entry update state; a new one is accepted as the last commits.
// A waiting result holds the update cycle until the output register drains.
// Reset (rst, synchronous): all entries invalid, stamps and use counter zero,
// block size register = 1, source_length = 0.
// ---------------------------------------------------------------------------
// Expert slot cache top level
// Fully associative expert id cache with timestamp LRU replacement.
// ---------------------------------------------------------------------------
module expert_slot_lru_cache_unit #(
  parameter int unsigned WAYS = eslc_pkg::WAYS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [eslc_pkg::S_DATA_W-1:0]   s_tdata,   // expert_index[15:0], source_offset[55:16]
  input  logic                            s_tuser,   // operation[0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [eslc_pkg::M_DATA_W-1:0]   m_tdata,   // entry_used[2:0], staging_offset[37:3], zero[39:38]
  output logic [1:0]                      m_tuser,   // status[1:0]
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [eslc_pkg::CFG_W-1:0]      cfg_data
);

  eslc_pkg::cmd_t    cmd;
  eslc_pkg::stat_t   stat;
  eslc_pkg::status_t out_status;
  logic [eslc_pkg::ENT_W-1:0] out_entry;
  logic [eslc_pkg::LOC_W-1:0] out_loc;

  eslc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  eslc_datapath #(
    .WAYS (WAYS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser),
    .in_id      (s_tdata[15:0]),
    .in_off     (s_tdata[55:16]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_loc    (out_loc)
  );

  assign m_tdata = {2'b00, out_loc, out_entry};
  assign m_tuser = out_status;

endmodule

### hw/rtl/eslc_checker.sv
// ---------------------------------------------------------------------------
// Expert slot cache checker
// Port-level checks on request sequencing and result payloads.
// ---------------------------------------------------------------------------
`include "expert_slot_lru_cache_unit_assert.svh"

module eslc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [eslc_pkg::M_DATA_W-1:0] m_tdata,
  input logic [1:0]                    m_tuser
);

  `ESLC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `ESLC_ASSERT_SAME(a_clear_zero, m_tvalid && m_tuser == eslc_pkg::ST_CLEARED, m_tdata == '0)
  `ESLC_ASSERT_SAME(a_range_zero, m_tvalid && m_tuser == eslc_pkg::ST_RANGE, m_tdata == '0)
  `ESLC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

endmodule

bind expert_slot_lru_cache_unit eslc_checker u_eslc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
